// ----- rtl/eptp_pkg.sv -----
// ----------------------------------------------------------------------------
// eptp_pkg
// Shared types, constants and the arctangent table for the pointing unit.
// ----------------------------------------------------------------------------
package eptp_pkg;

    localparam int VW = 36;
    localparam int ZW = 34;
    localparam logic signed [VW-1:0] GAIN_Q30 = 36'sd652032874;

    localparam logic [3:0] REG_LATITUDE = 4'd0;
    localparam logic [3:0] REG_SIDEREAL = 4'd1;

    typedef struct packed {
        logic        [15:0] right_ascension;
        logic signed [15:0] declination;
    } target_t;

    typedef struct packed {
        logic signed [11:0] altitude_count;
        logic        [12:0] azimuth_count;
    } result_t;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 flip;
    } rot_lane_t;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 base;
        logic                 zero;
    } vec_lane_t;

    function automatic logic [31:0] arc_entry(input int unsigned i);
        logic [31:0] r;
        case (i)
            0:  r = 32'h20000000;
            1:  r = 32'h12E4051E;
            2:  r = 32'h09FB385B;
            3:  r = 32'h051111D4;
            4:  r = 32'h028B0D43;
            5:  r = 32'h0145D7E1;
            6:  r = 32'h00A2F61E;
            7:  r = 32'h00517C55;
            8:  r = 32'h0028BE53;
            9:  r = 32'h00145F2F;
            10: r = 32'h000A2F98;
            11: r = 32'h000517CC;
            12: r = 32'h00028BE6;
            13: r = 32'h000145F3;
            14: r = 32'h0000A2F9;
            15: r = 32'h0000517C;
            16: r = 32'h000028BE;
            17: r = 32'h0000145F;
            18: r = 32'h00000A2F;
            19: r = 32'h00000517;
            20: r = 32'h0000028B;
            21: r = 32'h00000145;
            22: r = 32'h000000A2;
            23: r = 32'h00000051;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/eptp_rot_cell.sv -----
// ----------------------------------------------------------------------------
// eptp_rot_cell
// One rotation step of the CORDIC chain, applied to three angle lanes.
// ----------------------------------------------------------------------------
module eptp_rot_cell #(
    parameter int STEP = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  eptp_pkg::rot_lane_t [2:0]   in_lanes,
    output logic                        out_valid,
    output eptp_pkg::rot_lane_t [2:0]   out_lanes
);

    localparam logic signed [eptp_pkg::ZW-1:0] ARC =
        $signed({2'b00, eptp_pkg::arc_entry(STEP)});

    logic                       valid_reg;
    eptp_pkg::rot_lane_t [2:0]  lanes_reg;
    eptp_pkg::rot_lane_t [2:0]  lanes_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            lanes_next[k].flip = in_lanes[k].flip;
            if (!in_lanes[k].z[eptp_pkg::ZW-1])
            begin
                lanes_next[k].x = $signed(in_lanes[k].x) - ($signed(in_lanes[k].y) >>> STEP);
                lanes_next[k].y = $signed(in_lanes[k].y) + ($signed(in_lanes[k].x) >>> STEP);
                lanes_next[k].z = $signed(in_lanes[k].z) - ARC;
            end
            else
            begin
                lanes_next[k].x = $signed(in_lanes[k].x) + ($signed(in_lanes[k].y) >>> STEP);
                lanes_next[k].y = $signed(in_lanes[k].y) - ($signed(in_lanes[k].x) >>> STEP);
                lanes_next[k].z = $signed(in_lanes[k].z) + ARC;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lanes_reg <= lanes_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_lanes = lanes_reg;

endmodule

// ----- rtl/eptp_vec_cell.sv -----
// ----------------------------------------------------------------------------
// eptp_vec_cell
// One vectoring step of the CORDIC chain, with a sideband word carried along.
// ----------------------------------------------------------------------------
module eptp_vec_cell #(
    parameter int STEP   = 0,
    parameter int SIDE_W = 36
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  eptp_pkg::vec_lane_t     in_lane,
    input  logic [SIDE_W-1:0]       in_side,
    output logic                    out_valid,
    output eptp_pkg::vec_lane_t     out_lane,
    output logic [SIDE_W-1:0]       out_side
);

    localparam logic signed [eptp_pkg::ZW-1:0] ARC =
        $signed({2'b00, eptp_pkg::arc_entry(STEP)});

    logic                   valid_reg;
    eptp_pkg::vec_lane_t    lane_reg;
    eptp_pkg::vec_lane_t    lane_next;
    logic [SIDE_W-1:0]      side_reg;

    always_comb
    begin
        lane_next.base = in_lane.base;
        lane_next.zero = in_lane.zero;
        if ($signed(in_lane.y) > 0)
        begin
            lane_next.x = $signed(in_lane.x) + ($signed(in_lane.y) >>> STEP);
            lane_next.y = $signed(in_lane.y) - ($signed(in_lane.x) >>> STEP);
            lane_next.z = $signed(in_lane.z) + ARC;
        end
        else
        begin
            lane_next.x = $signed(in_lane.x) - ($signed(in_lane.y) >>> STEP);
            lane_next.y = $signed(in_lane.y) + ($signed(in_lane.x) >>> STEP);
            lane_next.z = $signed(in_lane.z) - ARC;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_lane  = lane_reg;
    assign out_side  = side_reg;

endmodule

// ----- rtl/equatorial_to_encoder_pointing_unit.sv -----
// ----------------------------------------------------------------------------
// equatorial_to_encoder_pointing_unit
// Converts right ascension and declination to altitude/azimuth encoder counts.
// ----------------------------------------------------------------------------
// Usage:
//   target channel (target_valid/target_stall/target) carries one transaction
//   per target; result channel (result_valid/result_stall/result) returns one
//   transaction with both encoder setpoints, in order.
//   cfg channel writes latitude (index 0) and sidereal angle (index 1); other
//   indexes are dropped. cfg_ready is always high; write only while idle.
//   The path runs through the input register, rotation cells, two multiply
//   stages, two vectoring cell rows each followed by a multiply stage, and
//   the output register.
//   Throughput is one target per cycle while target_stall is low, set by the cell rows advancing together.
//   When the receiver stalls, the held result stays and one more result goes
//   into a skid register; target_stall then rises and the whole row of cells
//   holds until the skid drains.
//   Reset clears all valid bits and both configuration registers to zero.
// ----------------------------------------------------------------------------
module equatorial_to_encoder_pointing_unit #(
    parameter int ALT_COUNTS_PER_TURN = 4096,
    parameter int AZ_COUNTS_PER_TURN  = 4096,
    parameter int CORDIC_STEPS        = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                target_valid,
    output logic                target_stall,
    input  eptp_pkg::target_t   target,
    output logic                result_valid,
    input  logic                result_stall,
    output eptp_pkg::result_t   result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [3:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    localparam int VW = eptp_pkg::VW;
    localparam int ZW = eptp_pkg::ZW;
    localparam int PW = 50;
    localparam logic signed [17:0] ALT_N = 18'(ALT_COUNTS_PER_TURN);
    localparam logic signed [17:0] AZ_N  = 18'(AZ_COUNTS_PER_TURN);
    localparam logic signed [19:0] ALT_LIM = 20'(ALT_COUNTS_PER_TURN / 4);
    localparam logic signed [19:0] AZ_ADD  = 20'(AZ_COUNTS_PER_TURN);
    localparam logic signed [PW-1:0] ROUND_HALF = PW'(64'sh80000000);

    logic [15:0]            latitude_reg;
    logic [15:0]            sidereal_reg;
    logic                   en;
    logic                   accept;

    logic                   v0_reg;
    logic [15:0]            ang_reg [3];

    eptp_pkg::rot_lane_t [2:0]  rot_bus [CORDIC_STEPS+1];
    logic                       rot_v   [CORDIC_STEPS+1];

    logic signed [VW-1:0]   sn [3];
    logic signed [VW-1:0]   cs [3];

    logic                   v1_reg;
    logic signed [VW-1:0]   p_sdsl_reg, p_sdcl_reg, p_cdcl_reg, p_cdsl_reg;
    logic signed [VW-1:0]   east_reg, ch_reg;
    logic signed [2*VW-1:0] m_sdsl, m_sdcl, m_cdcl, m_cdsl, m_east;

    logic                   v2_reg;
    logic signed [VW-1:0]   up_reg, north_reg, east2_reg;
    logic signed [2*VW-1:0] m_up, m_north;

    eptp_pkg::vec_lane_t    va_bus  [CORDIC_STEPS+1];
    logic [VW-1:0]          va_side [CORDIC_STEPS+1];
    logic                   va_v    [CORDIC_STEPS+1];

    logic                   v3_reg;
    logic signed [VW-1:0]   horiz_reg, up3_reg;
    logic [31:0]            az3_reg;
    logic [31:0]            az_ang;
    logic signed [2*VW-1:0] m_mag;

    eptp_pkg::vec_lane_t    vb_bus  [CORDIC_STEPS+1];
    logic [31:0]            vb_side [CORDIC_STEPS+1];
    logic                   vb_v    [CORDIC_STEPS+1];

    logic                   v4_reg;
    logic signed [PW-1:0]   alt_prod_reg, az_prod_reg;
    logic [31:0]            alt_ang;

    logic signed [PW-1:0]   alt_sum, az_sum;
    logic signed [19:0]     alt_cnt, az_cnt;
    eptp_pkg::result_t      pipe_item;

    logic                   result_valid_reg;
    eptp_pkg::result_t      result_reg;
    logic                   skid_valid_reg;
    eptp_pkg::result_t      skid_reg;
    logic                   take;

    assign cfg_ready    = 1'b1;
    assign en           = !skid_valid_reg;
    assign target_stall = skid_valid_reg;
    assign accept       = target_valid && !target_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latitude_reg <= '0;
            sidereal_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                eptp_pkg::REG_LATITUDE: latitude_reg <= cfg_data;
                eptp_pkg::REG_SIDEREAL: sidereal_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang_reg[0] <= target.declination;
            ang_reg[1] <= latitude_reg;
            ang_reg[2] <= sidereal_reg - target.right_ascension;
        end
    end

    // fold into the right half plane
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            rot_bus[0][k].flip = (ang_reg[k][15] != ang_reg[k][14]);
            rot_bus[0][k].x    = eptp_pkg::GAIN_Q30;
            rot_bus[0][k].y    = '0;
            rot_bus[0][k].z    = $signed({{(ZW-31){ang_reg[k][15] ^ rot_bus[0][k].flip}},
                                          ang_reg[k][14:0], 16'b0});
        end
    end
    assign rot_v[0] = v0_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_rot
        eptp_rot_cell #(.STEP(i)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (rot_v[i]),
            .in_lanes  (rot_bus[i]),
            .out_valid (rot_v[i+1]),
            .out_lanes (rot_bus[i+1])
        );
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sn[k] = rot_bus[CORDIC_STEPS][k].flip ? -$signed(rot_bus[CORDIC_STEPS][k].y)
                                                  :  $signed(rot_bus[CORDIC_STEPS][k].y);
            cs[k] = rot_bus[CORDIC_STEPS][k].flip ? -$signed(rot_bus[CORDIC_STEPS][k].x)
                                                  :  $signed(rot_bus[CORDIC_STEPS][k].x);
        end
    end

    // first products
    assign m_sdsl = sn[0] * sn[1];
    assign m_sdcl = sn[0] * cs[1];
    assign m_cdcl = cs[0] * cs[1];
    assign m_cdsl = cs[0] * sn[1];
    assign m_east = cs[0] * sn[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= rot_v[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_sdsl_reg <= m_sdsl[VW+29:30];
            p_sdcl_reg <= m_sdcl[VW+29:30];
            p_cdcl_reg <= m_cdcl[VW+29:30];
            p_cdsl_reg <= m_cdsl[VW+29:30];
            east_reg   <= m_east[VW+29:30];
            ch_reg     <= cs[2];
        end
    end

    // second products
    assign m_up    = p_cdcl_reg * ch_reg;
    assign m_north = p_cdsl_reg * ch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            up_reg    <= p_sdsl_reg + $signed(m_up[VW+29:30]);
            north_reg <= $signed(m_north[VW+29:30]) - p_sdcl_reg;
            east2_reg <= east_reg;
        end
    end

    // azimuth vectoring
    always_comb
    begin
        va_bus[0].zero = (north_reg == '0) && (east2_reg == '0);
        va_bus[0].base = north_reg[VW-1];
        va_bus[0].x    = north_reg[VW-1] ? -north_reg : north_reg;
        va_bus[0].y    = north_reg[VW-1] ? -east2_reg : east2_reg;
        va_bus[0].z    = '0;
    end
    assign va_side[0] = up_reg;
    assign va_v[0]    = v2_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_vec_az
        eptp_vec_cell #(.STEP(i), .SIDE_W(VW)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (va_v[i]),
            .in_lane   (va_bus[i]),
            .in_side   (va_side[i]),
            .out_valid (va_v[i+1]),
            .out_lane  (va_bus[i+1]),
            .out_side  (va_side[i+1])
        );
    end

    assign az_ang = va_bus[CORDIC_STEPS].zero ? 32'd0
                  : va_bus[CORDIC_STEPS].z[31:0] + {va_bus[CORDIC_STEPS].base, 31'b0};
    assign m_mag  = $signed(va_bus[CORDIC_STEPS].x) * eptp_pkg::GAIN_Q30;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= va_v[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            horiz_reg <= m_mag[VW+29:30];
            up3_reg   <= $signed(va_side[CORDIC_STEPS]);
            az3_reg   <= az_ang;
        end
    end

    // altitude vectoring
    always_comb
    begin
        vb_bus[0].zero = (horiz_reg == '0) && (up3_reg == '0);
        vb_bus[0].base = horiz_reg[VW-1];
        vb_bus[0].x    = horiz_reg[VW-1] ? -horiz_reg : horiz_reg;
        vb_bus[0].y    = horiz_reg[VW-1] ? -up3_reg : up3_reg;
        vb_bus[0].z    = '0;
    end
    assign vb_side[0] = az3_reg;
    assign vb_v[0]    = v3_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_vec_alt
        eptp_vec_cell #(.STEP(i), .SIDE_W(32)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (vb_v[i]),
            .in_lane   (vb_bus[i]),
            .in_side   (vb_side[i]),
            .out_valid (vb_v[i+1]),
            .out_lane  (vb_bus[i+1]),
            .out_side  (vb_side[i+1])
        );
    end

    assign alt_ang = vb_bus[CORDIC_STEPS].zero ? 32'd0
                   : vb_bus[CORDIC_STEPS].z[31:0] + {vb_bus[CORDIC_STEPS].base, 31'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= vb_v[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            alt_prod_reg <= PW'($signed(alt_ang) * ALT_N);
            az_prod_reg  <= PW'($signed(vb_side[CORDIC_STEPS]) * AZ_N);
        end
    end

    // round to counts
    always_comb
    begin
        alt_sum = alt_prod_reg + ROUND_HALF;
        az_sum  = az_prod_reg + ROUND_HALF;
        alt_cnt = 20'($signed(alt_sum[PW-1:32]));
        az_cnt  = 20'($signed(az_sum[PW-1:32]));
        if (alt_cnt > ALT_LIM)
        begin
            alt_cnt = ALT_LIM;
        end
        if (alt_cnt < -ALT_LIM)
        begin
            alt_cnt = -ALT_LIM;
        end
        if (az_cnt <= 0)
        begin
            az_cnt = az_cnt + AZ_ADD;
        end
        pipe_item.altitude_count = alt_cnt[11:0];
        pipe_item.azimuth_count  = az_cnt[12:0];
    end

    // output register and skid
    assign take = result_valid_reg && !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else if (!result_valid_reg || take)
        begin
            result_valid_reg <= skid_valid_reg || (v4_reg && en);
            skid_valid_reg   <= 1'b0;
        end
        else if (v4_reg && en)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!result_valid_reg || take)
        begin
            result_reg <= skid_valid_reg ? skid_reg : pipe_item;
        end
        else if (v4_reg && en)
        begin
            skid_reg <= pipe_item;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_skid_behind_output: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> result_valid_reg)
        else $error("skid holds a result while the output register is empty");

    a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(result_valid_reg && result_stall && v4_reg))
        else $error("skid filled without a stalled output");

    a_last_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && !en) |=> v4_reg)
        else $error("last stage lost a result while the row was held");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !result_stall) |=> (!skid_valid_reg && result_valid_reg))
        else $error("skid did not move into the output register");

endmodule

// ----- verif/tb_equatorial_to_encoder_pointing_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pointing unit testbench
// Drives targets through several latitude and sidereal settings, predicts
// both encoder setpoints with a CORDIC model of its own and checks each
// result transaction in order against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_equatorial_to_encoder_pointing_unit;

    localparam int ALT_CPT = 4096;
    localparam int AZ_CPT = 4096;
    localparam int STEPS = 16;
    localparam int LATENCY = 3 * STEPS + 6;
    localparam longint GAIN = 64'sd652032874;
    localparam longint HALF_TURN = 64'sd2147483648;
    localparam int RANDOM_ITEMS = 1920;
    localparam int MAX_CYCLES = 800000;

    logic clk;
    logic rst_n;
    logic target_valid;
    logic target_stall;
    eptp_pkg::target_t target;
    logic result_valid;
    logic result_stall;
    eptp_pkg::result_t result;
    logic cfg_valid;
    logic cfg_ready;
    logic [3:0] cfg_index;
    logic [15:0] cfg_data;

    int failures;
    longint cycle_count;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint to_signed32(logic [31:0] a);
        return longint'($signed(a));
    endfunction

    function automatic longint arc_angle(int i);
        longint t [24] = '{
            64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
            64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
            64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
            64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C,
            64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
            64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051};
        return t[i];
    endfunction

    function automatic longint qmul(longint a, longint b);
        return floor_shift(a * b, 30);
    endfunction

    function automatic void sin_cos(input logic [31:0] ang, output longint s,
                                    output longint c);
        logic [31:0] a;
        bit flip;
        longint x, y, z, nx, ny;
        a = ang;
        flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
        if (flip)
            a = a + 32'h80000000;
        x = GAIN;
        y = 0;
        z = to_signed32(a);
        for (int i = 0; i < STEPS && i < 24; i++)
        begin
            if (z >= 0)
            begin
                nx = x - floor_shift(y, i); ny = y + floor_shift(x, i); z -= arc_angle(i);
            end
            else
            begin
                nx = x + floor_shift(y, i); ny = y - floor_shift(x, i); z += arc_angle(i);
            end
            x = nx; y = ny;
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic void arctan_mag(input longint xi, input longint yi,
                                       output logic [31:0] ang, output longint mag);
        longint x, y, z, nx, ny;
        logic [31:0] base;
        x = xi; y = yi; z = 0; base = 0;
        if (x == 0 && y == 0)
        begin
            mag = 0;
            ang = 0;
            return;
        end
        if (x < 0)
        begin
            x = -x; y = -y; base = 32'h80000000;
        end
        for (int i = 0; i < STEPS && i < 24; i++)
        begin
            if (y > 0)
            begin
                nx = x + floor_shift(y, i); ny = y - floor_shift(x, i); z += arc_angle(i);
            end
            else
            begin
                nx = x - floor_shift(y, i); ny = y + floor_shift(x, i); z -= arc_angle(i);
            end
            x = nx; y = ny;
        end
        mag = qmul(x, GAIN);
        ang = base + z[31:0];
    endfunction

    class pointing_scoreboard;
        logic [15:0] latitude;
        logic [15:0] sidereal;
        eptp_pkg::result_t setpoints [$];

        function void note_target(eptp_pkg::target_t t);
            logic [15:0] ha;
            longint sd, cd, sl, cl, sh, ch, up, north, east, horiz, unused, alt, az, cnt;
            logic [31:0] a;
            eptp_pkg::result_t r;
            ha = sidereal - t.right_ascension;
            sin_cos({t.declination, 16'h0}, sd, cd);
            sin_cos({latitude, 16'h0}, sl, cl);
            sin_cos({ha, 16'h0}, sh, ch);
            up = qmul(sd, sl) + qmul(qmul(cd, cl), ch);
            north = -qmul(sd, cl) + qmul(qmul(cd, sl), ch);
            east = qmul(cd, sh);
            arctan_mag(north, east, a, horiz);
            az = to_signed32(a);
            arctan_mag(horiz, up, a, unused);
            alt = to_signed32(a);
            cnt = floor_shift(alt * ALT_CPT + HALF_TURN, 32);
            if (cnt > ALT_CPT / 4) cnt = ALT_CPT / 4;
            if (cnt < -ALT_CPT / 4) cnt = -ALT_CPT / 4;
            r.altitude_count = cnt[11:0];
            cnt = floor_shift(az * AZ_CPT + HALF_TURN, 32);
            if (cnt <= 0) cnt += AZ_CPT;
            r.azimuth_count = cnt[12:0];
            setpoints.push_back(r);
        endfunction

        function int check_result(eptp_pkg::result_t got);
            eptp_pkg::result_t e;
            int errs;
            errs = 0;
            if (setpoints.size() == 0)
            begin
                $error("unexpected result transaction alt=%0d az=%0d",
                       got.altitude_count, got.azimuth_count);
                return 1;
            end
            e = setpoints.pop_front();
            if (got.altitude_count !== e.altitude_count)
            begin
                $error("altitude_count expected %0d actual %0d",
                       e.altitude_count, got.altitude_count);
                errs++;
            end
            if (got.azimuth_count !== e.azimuth_count)
            begin
                $error("azimuth_count expected %0d actual %0d",
                       e.azimuth_count, got.azimuth_count);
                errs++;
            end
            return errs;
        endfunction
    endclass

    pointing_scoreboard pointing;

    equatorial_to_encoder_pointing_unit dut (
        .clk(clk), .rst_n(rst_n),
        .target_valid(target_valid), .target_stall(target_stall), .target(target),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("equatorial_to_encoder_pointing_unit: mismatch");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            failures <= failures + pointing.check_result(result);
    end

    int stall_left;
    bit calm;
    always @(posedge clk)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else if (calm)
            result_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            stall_left <= pick_gap();
            result_stall <= 1'b0;
        end
    end

    task automatic send_target(eptp_pkg::target_t t, bit gaps);
        int g;
        g = gaps ? pick_gap() : 0;
        if (g > 0)
        begin
            target_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        target_valid <= 1'b1;
        target <= t;
        do @(posedge clk); while (target_stall);
        pointing.note_target(t);
    endtask

    task automatic write_register(logic [3:0] idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == eptp_pkg::REG_LATITUDE) pointing.latitude = value;
        else if (idx == eptp_pkg::REG_SIDEREAL) pointing.sidereal = value;
        @(posedge clk);
    endtask

    task automatic drain();
        target_valid <= 1'b0;
        while (pointing.setpoints.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic eptp_pkg::target_t random_target();
        eptp_pkg::target_t t;
        int r;
        t.right_ascension = 16'($urandom);
        r = $urandom_range(0, 9);
        if (r == 0) t.declination = 16'($urandom);
        else t.declination = 16'($urandom_range(0, 32768) - 16384);
        return t;
    endfunction

    logic [15:0] lat_settings [6] = '{16'h0000, 16'h4000, 16'hC000, 16'h1555, 16'hF000, 16'h7FFF};
    logic [15:0] sid_settings [6] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h3A21, 16'h0001, 16'hC3C3};

    initial
    begin
        eptp_pkg::target_t t;
        pointing = new();
        pointing.latitude = 0;
        pointing.sidereal = 0;
        failures = 0;
        cycle_count = 0;
        calm = 1'b0;
        stall_left = 0;
        clk = 1'b0;
        rst_n = 1'b0;
        target_valid = 1'b0;
        target = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (lat_settings[k])
        begin
            bit [15:0] ra_list [5] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h4000, 16'hC000};
            bit [15:0] dec_list [5] = '{16'h4000, 16'hC000, 16'h0000, 16'h7FFF, 16'h8000};
            write_register(eptp_pkg::REG_LATITUDE, lat_settings[k]);
            write_register(eptp_pkg::REG_SIDEREAL, sid_settings[k]);
            write_register(4'hF, 16'hFFFF);
            if (k == 0)
            begin
                foreach (ra_list[i])
                    foreach (dec_list[j])
                        if (i == j || j < 2)
                        begin
                            t.right_ascension = ra_list[i];
                            t.declination = dec_list[j];
                            send_target(t, 1'b0);
                        end
                t.right_ascension = 16'h0000;
                t.declination = 16'h4000;
                send_target(t, 1'b0);
            end
            calm = (k == 2);
            for (int n = 0; n < RANDOM_ITEMS / 6; n++)
            begin
                if (k == 3 && n < 2)
                begin
                    t.right_ascension = sid_settings[k];
                    t.declination = n ? 16'h4000 - lat_settings[k] : 16'h4000;
                    send_target(t, 1'b0);
                end
                else
                    send_target(random_target(), (k != 2));
            end
            drain();
            calm = 1'b0;
        end

        t.right_ascension = 16'h0;
        t.declination = 16'h0;
        write_register(eptp_pkg::REG_LATITUDE, 16'h8001);
        write_register(eptp_pkg::REG_SIDEREAL, 16'h5A5A);
        for (int n = 0; n < 12; n++)
            send_target(random_target(), 1'b1);
        drain();
        repeat (LATENCY) @(posedge clk);
        if (failures == 0 && pointing.setpoints.size() == 0)
            $display("equatorial_to_encoder_pointing_unit: match");
        else
            $display("equatorial_to_encoder_pointing_unit: mismatch");
        $finish;
    end
endmodule
